// ----- rtl/cube_map_face_uv_top_assert.svh -----
// Assertion macros for the cube map face / uv block.
// Used by cube_map_face_uv_top; expects a clk and rst in scope.
`ifndef CUBE_MAP_FACE_UV_TOP_ASSERT_SVH
`define CUBE_MAP_FACE_UV_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CMF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cmf_pkg.sv -----
// Shared face codes and the face/flag tag type for the cube map face block.
// No dependencies.
package cmf_pkg;

  localparam int FACE_W = 3;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

  // face index plus the all-zero direction flag
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              zero;
  } cmf_tag_t;

endpackage

// ----- rtl/cmf_face_sel.sv -----
// Two-stage major-axis selection: magnitudes, then face, major magnitude
// and signed minor components. Depends on cmf_pkg.
module cmf_face_sel #(
  parameter int CB = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [CB-1:0] dir_x,
  input  logic signed [CB-1:0] dir_y,
  input  logic signed [CB-1:0] dir_z,
  output cmf_pkg::cmf_tag_t  tag,
  output logic [CB-1:0]      mag,
  output logic signed [CB:0] coord_u,
  output logic signed [CB:0] coord_v
);
  import cmf_pkg::*;

  logic signed [CB-1:0] x_q, y_q, z_q;
  logic [CB-1:0]        ax_q, ay_q, az_q;
  logic [CB-1:0]        ax, ay, az;

  // magnitudes; the most negative value maps to 2^(CB-1) as unsigned
  always_comb begin
    ax = dir_x[CB-1] ? $unsigned(-dir_x) : $unsigned(dir_x);
    ay = dir_y[CB-1] ? $unsigned(-dir_y) : $unsigned(dir_y);
    az = dir_z[CB-1] ? $unsigned(-dir_z) : $unsigned(dir_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q  <= dir_x;
      y_q  <= dir_y;
      z_q  <= dir_z;
      ax_q <= ax;
      ay_q <= ay;
      az_q <= az;
    end
  end

  logic signed [CB:0] xe, ye, ze, nx, ny;
  logic               sel_z, sel_y, pos_x, pos_y, pos_z;
  logic [FACE_W-1:0]  face_c;
  logic [CB-1:0]      m_c;
  logic signed [CB:0] u_c, v_c;

  always_comb begin
    xe    = {x_q[CB-1], x_q};
    ye    = {y_q[CB-1], y_q};
    ze    = {z_q[CB-1], z_q};
    nx    = -xe;
    ny    = -ye;
    pos_x = !x_q[CB-1] && (x_q != '0);
    pos_y = !y_q[CB-1] && (y_q != '0);
    pos_z = !z_q[CB-1] && (z_q != '0);
    // ties go to z, then y
    sel_z = (az_q >= ax_q) && (az_q >= ay_q);
    sel_y = (ay_q >= ax_q);
    priority if (sel_z) begin
      m_c = az_q;
      v_c = ny;
      if (pos_z) begin
        face_c = FACE_PZ;
        u_c    = nx;
      end else begin
        face_c = FACE_NZ;
        u_c    = xe;
      end
    end else if (sel_y) begin
      m_c = ay_q;
      v_c = ze;
      if (pos_y) begin
        face_c = FACE_PY;
        u_c    = nx;
      end else begin
        face_c = FACE_NY;
        u_c    = xe;
      end
    end else begin
      m_c = ax_q;
      v_c = ze;
      if (pos_x) begin
        face_c = FACE_PX;
        u_c    = ye;
      end else begin
        face_c = FACE_NX;
        u_c    = ny;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag.face <= face_c;
      tag.zero <= (m_c == '0);
      mag      <= m_c;
      coord_u  <= u_c;
      coord_v  <= v_c;
    end
  end

endmodule

// ----- rtl/cmf_div.sv -----
// Pipelined restoring divider for one coordinate: (c+m) * 2^(UV-1) / m,
// UV+1 stages: add, integer part, then one fraction bit each. Depends on cmf_pkg.
module cmf_div #(
  parameter int CB = 16,
  parameter int UV = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [CB:0] coord,
  input  logic [CB-1:0]      mag,
  output logic [UV:0]        quot
);
  import cmf_pkg::*;

  logic [CB:0]   a_q;
  logic [CB-1:0] m_p [UV];
  logic [CB-1:0] r_p [1:UV-1];
  logic [UV:0]   q_p [1:UV];

  // stage 0: a = c + m, in [0, 2m]
  logic signed [CB+1:0] sum;
  assign sum = {coord[CB], coord} + $signed({2'b00, mag});

  always_ff @(posedge clk) begin
    if (en) begin
      a_q    <= sum[CB:0];
      m_p[0] <= mag;
    end
  end

  // stage 1: integer part of a/m is 0, 1 or 2
  logic [CB:0]   two_m, a_m;
  logic [1:0]    q0;
  logic [CB-1:0] r0;

  always_comb begin
    two_m = {m_p[0], 1'b0};
    a_m   = a_q - {1'b0, m_p[0]};
    priority if (a_q == two_m) begin
      q0 = 2'd2;
      r0 = '0;
    end else if (a_q >= {1'b0, m_p[0]}) begin
      q0 = 2'd1;
      r0 = a_m[CB-1:0];
    end else begin
      q0 = 2'd0;
      r0 = a_q[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_p[1] <= r0;
      q_p[1] <= {{(UV-1){1'b0}}, q0};
      m_p[1] <= m_p[0];
    end
  end

  // stages 2..UV: one fraction bit each; remainder stays below m
  for (genvar j = 2; j <= UV; j++) begin : g_bit
    logic [CB-1:0] r2;
    logic          ge;
    assign r2 = {r_p[j-1][CB-2:0], 1'b0};
    assign ge = (r2 >= m_p[j-1]);

    always_ff @(posedge clk) begin
      if (en) begin
        q_p[j] <= {q_p[j-1][UV-1:0], ge};
      end
    end

    if (j < UV) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_p[j] <= ge ? (r2 - m_p[j-1]) : r2;
          m_p[j] <= m_p[j-1];
        end
      end
    end
  end

  assign quot = q_p[UV];

endmodule

// ----- rtl/cube_map_face_uv_top.sv -----
// Cube map face selection with u/v coordinates, top level.
// Depends on cmf_pkg, cmf_face_sel, cmf_div and cube_map_face_uv_top_assert.svh.
//
// Maps a signed 3D direction to a cube face (0 +x, 1 -x, 2 +y, 3 -y, 4 +z,
// 5 -z; ties go to z, then y; a zero major component picks the negative face)
// and to u, v = floor(2^(UV_BITS-1) * (c + m) / m), saturated to all ones.
// A zero vector gives face 5, u = v = 0 and zero_dir set. The block takes
// one request per clock while s_tready is high and is fully pipelined: a
// result passes two face-selection stages, the divider (UV_BITS+1 stages:
// an add stage, an integer-part stage, then one compare and subtract per
// fraction bit), one saturation stage and the output register. A two-entry
// output buffer (output register plus skid register) keeps the pipeline
// advancing while a result waits, until a second result fills the skid
// register; s_tready is registered and drops only once the skid register
// holds a result.
`include "cube_map_face_uv_top_assert.svh"

module cube_map_face_uv_top #(
  parameter int COMP_BITS = 16,
  parameter int UV_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  // slave side: dir_x, dir_y, dir_z from the lowest bit up, zero padded
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((3*COMP_BITS+7)/8)*8-1:0]      s_tdata,
  // master side: face, tex_u, tex_v from the lowest bit up, zero padded
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((3+2*UV_BITS+7)/8)*8-1:0]      m_tdata,
  // zero_dir
  output logic                                  m_tuser
);
  import cmf_pkg::*;

  localparam int OUT_W  = FACE_W + 2 * UV_BITS;
  localparam int OUT_DW = ((3 + 2 * UV_BITS + 7) / 8) * 8;
  // face select (2) + divider (UV_BITS+1) + saturation (1)
  localparam int NST    = UV_BITS + 4;

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [UV_BITS-1:0] u;
    logic [UV_BITS-1:0] v;
    logic               zero;
  } res_t;

  // whole pipeline advances unless the skid register is occupied
  logic           skid_v;
  logic           en;
  logic [NST-1:0] vld;

  assign en       = !skid_v;
  assign s_tready = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // face selection, two stages
  cmf_tag_t                  tag;
  logic [COMP_BITS-1:0]      mag;
  logic signed [COMP_BITS:0] coord_u, coord_v;

  cmf_face_sel #(
    .CB (COMP_BITS)
  ) u_face_sel (
    .clk     (clk),
    .en      (en),
    .dir_x   ($signed(s_tdata[COMP_BITS-1:0])),
    .dir_y   ($signed(s_tdata[2*COMP_BITS-1:COMP_BITS])),
    .dir_z   ($signed(s_tdata[3*COMP_BITS-1:2*COMP_BITS])),
    .tag     (tag),
    .mag     (mag),
    .coord_u (coord_u),
    .coord_v (coord_v)
  );

  // one divider per coordinate
  logic [UV_BITS:0] quot_u, quot_v;

  cmf_div #(
    .CB (COMP_BITS),
    .UV (UV_BITS)
  ) u_div_u (
    .clk   (clk),
    .en    (en),
    .coord (coord_u),
    .mag   (mag),
    .quot  (quot_u)
  );

  cmf_div #(
    .CB (COMP_BITS),
    .UV (UV_BITS)
  ) u_div_v (
    .clk   (clk),
    .en    (en),
    .coord (coord_v),
    .mag   (mag),
    .quot  (quot_v)
  );

  // face and zero flag ride alongside the divider stages
  cmf_tag_t tag_p [UV_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      tag_p[0] <= tag;
      for (int j = 1; j <= UV_BITS; j++) begin
        tag_p[j] <= tag_p[j-1];
      end
    end
  end

  // saturation: quotient 2^UV_BITS only comes from c = +m
  res_t res;

  always_ff @(posedge clk) begin
    if (en) begin
      res.face <= tag_p[UV_BITS].face;
      res.zero <= tag_p[UV_BITS].zero;
      if (tag_p[UV_BITS].zero) begin
        res.u <= '0;
        res.v <= '0;
      end else begin
        res.u <= quot_u[UV_BITS] ? '1 : quot_u[UV_BITS-1:0];
        res.v <= quot_v[UV_BITS] ? '1 : quot_v[UV_BITS-1:0];
      end
    end
  end

  // output register plus skid register
  res_t out_q, skid_q;
  logic out_v, take;

  assign take = out_v && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (!out_v || take) begin
      out_v <= vld[NST-1];
    end else if (vld[NST-1]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (!out_v || take) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {{(OUT_DW-OUT_W){1'b0}}, out_q.v, out_q.u, out_q.face};
  assign m_tuser  = out_q.zero;

  `CMF_ASSERT_IMPLY(a_zero_out, m_tvalid && m_tuser, out_q.face == FACE_NZ && out_q.u == '0 && out_q.v == '0, "zero direction result not forced")
  `CMF_ASSERT_IMPLY(a_face_range, m_tvalid, out_q.face <= FACE_NZ, "face index out of range")
  `CMF_ASSERT_NEXT(a_entry, s_tvalid && s_tready, vld[0], "accepted request not captured")
  `CMF_ASSERT_NEXT(a_skid_hold, skid_v && !m_tready, skid_v && m_tvalid, "skid result dropped")

endmodule

// ----- sim/cube_map_face_uv_top_tb.sv -----
// Self-checking testbench for cube_map_face_uv_top: cube face and u/v per direction.
// Depends on cmf_pkg and the RTL of cube_map_face_uv_top; reads no files.
`timescale 1ns / 1ps

module cube_map_face_uv_top_tb;
  import cmf_pkg::*;

  localparam int COMP_W = 16;
  localparam int UV_W   = 16;
  localparam int UV_MAX = (1 << UV_W) - 1;
  localparam int IDLE_LIMIT = 2000;   // cycles with no handshake on either side
  localparam int LONG_HOLD  = 300;    // receiver hold-off, well past pipeline depth
  localparam int DRAIN_WAIT = 40;     // pipeline is UV_BITS+5 deep, plus slack

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } dir_t;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [UV_W-1:0]   u;
    logic [UV_W-1:0]   v;
    logic              zero;
  } face_uv_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // dir_x, dir_y, dir_z from bit 0 up
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // face, tex_u, tex_v from bit 0 up, zero pad
  logic        m_tuser;        // zero_dir

  cube_map_face_uv_top #(
    .COMP_BITS(COMP_W),
    .UV_BITS  (UV_W)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  dir_t     pending_dirs[$];     // requests not yet offered
  face_uv_t face_uv_due[$];      // predicted results, oldest first
  int       mismatches   = 0;
  int       tx_idle_pct  = 0;
  int       rx_stall_pct = 0;
  bit       dir_taken    = 1'b0; // set at the edge a request is accepted
  bit       hold_req     = 1'b0; // asks the receiver for one long hold-off
  bit       hold_done    = 1'b0;
  int       hold_cnt     = 0;
  int       idle_cycles  = 0;

  // ---------------------------------------------------------------------------
  // Predictor: face from the largest magnitude (z beats y beats x on a tie,
  // zero counts negative), then u/v = floor(2^(UV_W-1)*(c+m)/m), saturated.
  // ---------------------------------------------------------------------------
  function automatic logic [UV_W-1:0] uv_coord(longint c, longint m);
    longint q;
    q = ((c + m) <<< (UV_W - 1)) / m;
    if (q > UV_MAX) q = UV_MAX;
    return q[UV_W-1:0];
  endfunction

  function automatic face_uv_t predict_face_uv(dir_t d);
    longint x, y, z, ax, ay, az, m, uc, vc;
    face_uv_t r;
    x  = longint'($signed(d.x));
    y  = longint'($signed(d.y));
    z  = longint'($signed(d.z));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    if (az >= ax && az >= ay) begin
      m = az;
      if (z > 0) begin
        r.face = FACE_PZ; uc = -x; vc = -y;
      end else begin
        r.face = FACE_NZ; uc = x;  vc = -y;
      end
    end else if (ay >= ax) begin
      m = ay;
      if (y > 0) begin
        r.face = FACE_PY; uc = -x; vc = z;
      end else begin
        r.face = FACE_NY; uc = x;  vc = z;
      end
    end else begin
      m = ax;
      if (x > 0) begin
        r.face = FACE_PX; uc = y;  vc = z;
      end else begin
        r.face = FACE_NX; uc = -y; vc = z;
      end
    end
    if (m == 0) begin
      // zero vector: face already -z, coordinates forced to zero
      r.u = '0; r.v = '0; r.zero = 1'b1;
    end else begin
      r.u = uv_coord(uc, m); r.v = uv_coord(vc, m); r.zero = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [COMP_W-1:0] corner_value();
    case ($urandom_range(6))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  // component of magnitude m with a random sign, or something smaller
  function automatic logic signed [COMP_W-1:0] near_major(logic signed [COMP_W-1:0] m);
    case ($urandom_range(3))
      0: return m;
      1: return -m;
      2: return $signed(m) >>> $urandom_range(1, 4);
      default: return COMP_W'($urandom_range(0, 8) - 4);
    endcase
  endfunction

  function automatic dir_t random_dir();
    dir_t d;
    logic signed [COMP_W-1:0] m;
    d.x = COMP_W'($urandom);
    d.y = COMP_W'($urandom);
    d.z = COMP_W'($urandom);
    m   = COMP_W'($urandom);
    case ($urandom_range(9))
      4: begin   // small values: many ties and zeros
        d.x = COMP_W'($urandom_range(0, 6) - 3);
        d.y = COMP_W'($urandom_range(0, 6) - 3);
        d.z = COMP_W'($urandom_range(0, 6) - 3);
      end
      5, 6: begin   // magnitude ties and minor equal to major
        d.x = near_major(m);
        d.y = near_major(m);
        d.z = near_major(m);
      end
      7: begin
        d.x = corner_value();
        d.y = corner_value();
        d.z = corner_value();
      end
      8: begin   // zero components at random, z most often
        if ($urandom_range(1)) d.x = '0;
        if ($urandom_range(1)) d.y = '0;
        if ($urandom_range(3) != 0) d.z = '0;
      end
      default: ;  // fully random
    endcase
    return d;
  endfunction

  task automatic queue_random(int n);
    repeat (n) pending_dirs.push_back(random_dir());
  endtask

  task automatic queue_dir(int x, int y, int z);
    dir_t d;
    d.x = COMP_W'(x);
    d.y = COMP_W'(y);
    d.z = COMP_W'(z);
    pending_dirs.push_back(d);
  endtask

  // wait until the sender has handed over every queued request
  task automatic wait_sent();
    while (pending_dirs.size() != 0 || s_tvalid) @(posedge clk);
  endtask

  // wait until every queued request is sent and every predicted result has come back
  task automatic wait_drained();
    wait_sent();
    while (face_uv_due.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one nonblocking update of valid/data per falling edge. A request
  // accepted at the last rising edge is retired; a new one may follow at once.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    logic        nxt_valid;
    logic [47:0] nxt_data;
    dir_t        d;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (dir_taken) nxt_valid = 1'b0;
      dir_taken = 1'b0;
      if (!nxt_valid && pending_dirs.size() != 0 &&
          $urandom_range(99) >= tx_idle_pct) begin
        d = pending_dirs.pop_front();
        nxt_data  = {d.z, d.y, d.x};
        nxt_valid = 1'b1;
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= nxt_data;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on accepted requests, checks accepted results in order,
  // and runs the no-progress watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    dir_t     d;
    face_uv_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        d.x = s_tdata[15:0];
        d.y = s_tdata[31:16];
        d.z = s_tdata[47:32];
        face_uv_due.push_back(predict_face_uv(d));
        dir_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (face_uv_due.size() == 0) begin
          report_mismatch("unexpected result tdata", m_tdata, 0);
        end else begin
          want = face_uv_due.pop_front();
          if (m_tdata[2:0] !== want.face)   report_mismatch("face", m_tdata[2:0], want.face);
          if (m_tdata[18:3] !== want.u)     report_mismatch("tex_u", m_tdata[18:3], want.u);
          if (m_tdata[34:19] !== want.v)    report_mismatch("tex_v", m_tdata[34:19], want.v);
          if (m_tuser !== want.zero)        report_mismatch("zero_dir", m_tuser, want.zero);
          if (m_tdata[39:35] !== 5'b0)      report_mismatch("tdata pad", m_tdata[39:35], 0);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no progress for %0d cycles, %0d results outstanding",
                   $time, IDLE_LIMIT, face_uv_due.size());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: each face, zero vector, tie order, saturation, most negative
    queue_dir(0, 0, 0);
    queue_dir(1, 0, 0);
    queue_dir(-1, 0, 0);
    queue_dir(0, 1, 0);
    queue_dir(0, -1, 0);
    queue_dir(0, 0, 1);
    queue_dir(0, 0, -1);
    queue_dir(5, 5, 0);               // x/y tie goes to y
    queue_dir(1, -1, 0);              // tie, y negative
    queue_dir(5, 5, 5);               // three-way tie goes to z
    queue_dir(-5, 5, -5);
    queue_dir(100, 100, -100);
    queue_dir(32767, -32768, 0);      // most negative wins on magnitude
    queue_dir(-32768, -32768, -32768);// minor = +m saturates, -m gives 0
    queue_dir(32767, 32767, 0);
    queue_dir(-32768, 0, 0);
    queue_dir(0, 0, -32768);
    queue_dir(32767, -32767, 32767);
    queue_dir(-32768, 32767, 32767);
    queue_dir(7, 3, -2);
    queue_dir(-1234, 20000, -19999);
    queue_dir(32767, 32767, 32767);
    wait_drained();

    // back to back, with one long receiver hold-off to fill the pipeline
    queue_random(120);
    while (pending_dirs.size() > 100) @(posedge clk);
    hold_req = 1'b1;
    while (!hold_done) @(posedge clk);
    hold_req = 1'b0;
    queue_random(80);
    wait_drained();

    tx_idle_pct = 50;
    queue_random(200);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 50;
    queue_random(200);
    wait_sent();

    tx_idle_pct  = 8;
    rx_stall_pct = 8;
    queue_random(200);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
